// File: rtl/s5udp_pkg.sv
// Package for the SOCKS5 UDP header deframer: byte roles, status codes and
// the fixed header offsets of the SOCKS5 UDP request header.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s5udp_pkg;

  // Role of one byte within the datagram
  typedef enum logic [2:0] {
    KindRsv     = 3'd0,
    KindFrag    = 3'd1,
    KindAtyp    = 3'd2,
    KindAddr    = 3'd3,
    KindHlen    = 3'd4,
    KindPort    = 3'd5,
    KindPayload = 3'd6,
    KindDrop    = 3'd7
  } byte_kind_e;

  // Status reported with the final byte
  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StShort = 3'd1,
    StFrag  = 3'd2,
    StAtyp  = 3'd3,
    StV4    = 3'd4,
    StHlen  = 3'd5,
    StHost  = 3'd6,
    StV6    = 3'd7
  } status_e;

  // Address type codes
  localparam logic [7:0] AtypIpv4 = 8'd1;
  localparam logic [7:0] AtypName = 8'd3;
  localparam logic [7:0] AtypIpv6 = 8'd4;

  // Header offsets and minimum lengths
  localparam int unsigned PosFrag     = 2;
  localparam int unsigned PosAtyp     = 3;
  localparam int unsigned HdrMin      = 4;
  localparam int unsigned HdrV4       = 10;
  localparam int unsigned HdrV6       = 22;
  localparam int unsigned HdrNameBase = 7;
  localparam int unsigned V4AddrBytes = 4;
  localparam int unsigned V6AddrBytes = 16;
  localparam int unsigned PortBytes   = 2;

endpackage

`default_nettype wire

// File: rtl/socks5_udp_header_deframer.sv
// SOCKS5 UDP header deframer top level: tags each datagram byte by its role
// and reports header status on the final byte. Depends on s5udp_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_byte_i, in_last_i
// out     | output    | out_valid_o / out_ready_i | out_byte_o, byte_kind_o,
//         |           |                           | field_index_o, out_last_o, status_o
//
// One byte per cycle while the result register is not held by a low out_ready_i:
// each transfer in is classified by a position compare and lands in the result register.
// The result register holds while out_ready_i is low; in_ready_o is high
// whenever that register is empty or is being taken in the same cycle.
// Reset clears the byte position, latched address type, hostname length and
// error; the same state is cleared after every final byte.
module socks5_udp_header_deframer
  import s5udp_pkg::*;
#(
  parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      byte_kind_o,
  output logic [7:0]      field_index_o,
  output logic            out_last_o,
  output logic [2:0]      status_o
);

  // Position counter width, and a compare width that also covers the longest
  // hostname header even when the position saturates low.
  localparam int unsigned PosW = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam int unsigned CmpW = (PosW > 9) ? PosW + 1 : 10;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_DATAGRAM_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      atyp_q, atyp_d;
  logic [7:0]      hlen_q, hlen_d;
  logic [2:0]      err_q, err_d;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  byte_kind_e      kind_q, kind_d;
  logic [7:0]      idx_q, idx_d;
  logic            out_last_q;
  status_e         status_q, status_d;

  logic            in_xfer;
  logic [CmpW-1:0] p_w, n_w, hlen_w, addr_end, port_end, diff;
  logic [7:0]      hlen_cur;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Byte classification and header state update
  always_comb begin
    atyp_d   = atyp_q;
    hlen_d   = hlen_q;
    err_d    = err_q;
    kind_d   = KindPayload;
    idx_d    = 8'd0;
    diff     = '0;
    p_w      = CmpW'(pos_q);
    n_w      = p_w + CmpW'(1);
    hlen_cur = (atyp_q == AtypName && p_w == CmpW'(HdrMin)) ? in_byte_i : hlen_q;
    hlen_w   = CmpW'(hlen_cur);

    // Address and port boundaries for the latched address type
    if (atyp_q == AtypName) begin
      addr_end = CmpW'(HdrMin + 1) + hlen_w;
    end else if (atyp_q == AtypIpv4) begin
      addr_end = CmpW'(HdrMin + V4AddrBytes);
    end else begin
      addr_end = CmpW'(HdrMin + V6AddrBytes);
    end
    port_end = addr_end + CmpW'(PortBytes);

    if (err_q != 3'd0) begin
      kind_d = KindDrop;
    end else if (p_w < CmpW'(PosFrag)) begin
      kind_d = KindRsv;
    end else if (p_w == CmpW'(PosFrag)) begin
      kind_d = KindFrag;
      if (in_byte_i != 8'd0) err_d = StFrag;
    end else if (p_w == CmpW'(PosAtyp)) begin
      kind_d = KindAtyp;
      atyp_d = in_byte_i;
      if (in_byte_i != AtypIpv4 && in_byte_i != AtypName && in_byte_i != AtypIpv6) begin
        err_d = StAtyp;
      end
    end else begin
      hlen_d = hlen_cur;
      if (atyp_q == AtypName && p_w == CmpW'(HdrMin)) begin
        kind_d = KindHlen;
      end else if (p_w < addr_end) begin
        kind_d = KindAddr;
        diff   = (atyp_q == AtypName) ? p_w - CmpW'(HdrMin + 1) : p_w - CmpW'(HdrMin);
        idx_d  = diff[7:0];
      end else if (p_w < port_end) begin
        kind_d = KindPort;
        diff   = p_w - addr_end;
        idx_d  = diff[7:0];
      end
    end

    // Final byte status, formed from the state as updated by this byte
    status_d = StOk;
    if (in_last_i) begin
      if (n_w < CmpW'(HdrMin)) begin
        status_d = StShort;
      end else if (err_d != 3'd0) begin
        status_d = status_e'(err_d);
      end else if (atyp_d == AtypIpv4) begin
        status_d = (n_w < CmpW'(HdrV4)) ? StV4 : StOk;
      end else if (atyp_d == AtypIpv6) begin
        status_d = (n_w < CmpW'(HdrV6)) ? StV6 : StOk;
      end else if (n_w < CmpW'(HdrMin + 1)) begin
        status_d = StHlen;
      end else begin
        status_d = (n_w < CmpW'(HdrNameBase) + hlen_w) ? StHost : StOk;
      end
    end

    // Next position: clear after the final byte, else count and saturate
    if (in_last_i) begin
      pos_d  = '0;
      atyp_d = 8'd0;
      hlen_d = 8'd0;
      err_d  = 3'd0;
    end else if (pos_q < PosMax) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Header state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      atyp_q <= 8'd0;
      hlen_q <= 8'd0;
      err_q  <= 3'd0;
    end else if (in_xfer) begin
      pos_q  <= pos_d;
      atyp_q <= atyp_d;
      hlen_q <= hlen_d;
      err_q  <= err_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_byte_q <= in_byte_i;
      kind_q     <= kind_d;
      idx_q      <= idx_d;
      out_last_q <= in_last_i;
      status_q   <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_kind_o   = kind_q;
  assign field_index_o = idx_q;
  assign out_last_o    = out_last_q;
  assign status_o      = status_q;

  // Status is only reported on the final byte
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> status_q == StOk)
    else $error("status set on a non-final byte");

  // Field index is only used inside address and port fields
  a_idx_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KindAddr && kind_q != KindPort |-> idx_q == 8'd0)
    else $error("field index outside address or port field");

  // Port field is two bytes long
  a_port_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KindPort |-> idx_q < 8'd2)
    else $error("port index out of range");

  // A dropped final byte carries a latched error
  a_drop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q && kind_q == KindDrop |-> status_q == StFrag ||
      status_q == StAtyp || status_q == StShort)
    else $error("dropped final byte without error status");

  // State is cleared after the final byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_last_i |=> pos_q == '0 && err_q == 3'd0 && atyp_q == 8'd0)
    else $error("state not cleared after final byte");

endmodule

`default_nettype wire

// File: sim/socks5_udp_header_deframer_tb.sv
`timescale 1ns / 1ps
// Testbench for socks5_udp_header_deframer: streams datagrams byte by byte over
// valid/ready with random gaps and checks every tagged byte against an in-bench
// model of the header parser. Depends on s5udp_pkg and the deframer RTL.

module socks5_udp_header_deframer_tb
  import s5udp_pkg::*;
();

  // Small datagram limit so the saturation test stays short
  localparam int unsigned MaxBytes    = 300;
  localparam int unsigned RandomBytes = 1400;

  typedef logic [7:0] dgram_t [$];

  // One tagged byte as the block reports it
  typedef struct packed {
    logic [7:0] data;
    byte_kind_e kind;
    logic [7:0] idx;
    logic       last;
    status_e    st;
  } byte_role_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic [7:0] field_index;
  logic       out_last;
  logic [2:0] status;

  // Parser state of the bench model
  logic [15:0] pos_q;
  logic [7:0]  atyp_q;
  logic [7:0]  hlen_q;
  status_e     err_q;

  byte_role_t  role_exp_q [$];
  int          fail_cnt;
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned rx_hold_cycles;

  socks5_udp_header_deframer #(
    .MAX_DATAGRAM_BYTES(MaxBytes)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .byte_kind_o  (byte_kind),
    .field_index_o(field_index),
    .out_last_o   (out_last),
    .status_o     (status)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("** socks5_udp_header_deframer: FAILED **");
    $finish;
  end

  function automatic void clear_parser();
    pos_q  = '0;
    atyp_q = '0;
    hlen_q = '0;
    err_q  = StOk;
  endfunction

  // Append one byte to a datagram
  function automatic void add_byte(ref dgram_t d, input logic [7:0] b);
    d.insert(d.size(), b);
  endfunction

  // Queue one expected result
  function automatic void expect_role(input byte_role_t r);
    role_exp_q.insert(role_exp_q.size(), r);
  endfunction

  // Role, field index and status of one byte; advances the parser state
  function automatic byte_role_t classify_byte(logic [7:0] b, logic last);
    byte_role_t  r;
    int unsigned p, n, hl, base, addr_end;
    r.data = b;
    r.kind = KindPayload;
    r.idx  = '0;
    r.last = last;
    r.st   = StOk;
    p      = pos_q;
    hl     = hlen_q;
    if (err_q != StOk) begin
      r.kind = KindDrop;
    end else if (p < PosFrag) begin
      r.kind = KindRsv;
    end else if (p == PosFrag) begin
      r.kind = KindFrag;
      if (b != 8'h00) err_q = StFrag;
    end else if (p == PosAtyp) begin
      r.kind = KindAtyp;
      atyp_q = b;
      if (b != AtypIpv4 && b != AtypName && b != AtypIpv6) err_q = StAtyp;
    end else if (atyp_q == AtypName && p == HdrMin) begin
      r.kind = KindHlen;
      hlen_q = b;
      hl     = b;
    end else begin
      // address area, then port, then payload
      if (atyp_q == AtypName) begin
        base     = HdrMin + 1;
        addr_end = base + hl;
      end else if (atyp_q == AtypIpv4) begin
        base     = HdrMin;
        addr_end = HdrMin + V4AddrBytes;
      end else begin
        base     = HdrMin;
        addr_end = HdrMin + V6AddrBytes;
      end
      if (p < addr_end) begin
        r.kind = KindAddr;
        r.idx  = 8'(p - base);
      end else if (p < addr_end + PortBytes) begin
        r.kind = KindPort;
        r.idx  = 8'(p - addr_end);
      end
    end

    if (last) begin
      n = p + 1;
      if (n < HdrMin) r.st = StShort;
      else if (err_q != StOk) r.st = err_q;
      else if (atyp_q == AtypIpv4) r.st = (n < HdrV4) ? StV4 : StOk;
      else if (atyp_q == AtypIpv6) r.st = (n < HdrV6) ? StV6 : StOk;
      else if (n < HdrMin + 1) r.st = StHlen;
      else r.st = (n < HdrNameBase + hl) ? StHost : StOk;
      clear_parser();
    end else if (pos_q < MaxBytes) begin
      pos_q = pos_q + 16'd1;
    end
    return r;
  endfunction

  // Scoreboard: expectations enter on input transfers, leave on output transfers
  always @(posedge clk_i) begin
    byte_role_t got;
    byte_role_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = '{out_byte, byte_kind_e'(byte_kind), field_index, out_last,
                status_e'(status)};
        if (role_exp_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: output transfer with nothing expected, actual byte=%h kind=%0d idx=%0d last=%b st=%0d",
                   $time, got.data, got.kind, got.idx, got.last, got.st);
        end else begin
          want = role_exp_q.pop_front();
          if (got.data !== want.data || got.kind !== want.kind || got.idx !== want.idx ||
              got.last !== want.last || got.st !== want.st) begin
            fail_cnt++;
            $display("%0t: mismatch expected byte=%h kind=%0d idx=%0d last=%b st=%0d",
                     $time, want.data, want.kind, want.idx, want.last, want.st);
            $display("%0t:          actual   byte=%h kind=%0d idx=%0d last=%b st=%0d",
                     $time, got.data, got.kind, got.idx, got.last, got.st);
          end
        end
      end
      if (in_valid && in_ready) expect_role(classify_byte(in_byte, in_last));
    end
  end

  // Receiver: random wait per result, plus a long hold-off on request
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = (rx_gap_max != 0) ? $urandom_range(rx_gap_max, 0) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid && out_ready)) @(posedge clk_i);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255, 0));
  endfunction

  // Well-formed header: RSV, zero FRAG, ATYP, address, port
  function automatic dgram_t make_header(logic [7:0] atyp, int unsigned name_len);
    dgram_t d;
    add_byte(d, rand_byte());
    add_byte(d, rand_byte());
    add_byte(d, 8'h00);
    add_byte(d, atyp);
    if (atyp == AtypName) begin
      add_byte(d, 8'(name_len));
      repeat (name_len) add_byte(d, rand_byte());
    end else if (atyp == AtypIpv4) begin
      repeat (V4AddrBytes) add_byte(d, rand_byte());
    end else begin
      repeat (V6AddrBytes) add_byte(d, rand_byte());
    end
    repeat (PortBytes) add_byte(d, rand_byte());
    return d;
  endfunction

  // One input transfer, after a random gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = (tx_gap_max != 0) ? $urandom_range(tx_gap_max, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_datagram(input dgram_t d);
    for (int i = 0; i < d.size(); i++) send_byte(d[i], i == d.size() - 1);
  endtask

  // Every status, both error kinds, truncation at each header boundary
  task automatic test_directed_headers();
    dgram_t d;
    tx_gap_max = 3;
    rx_gap_max = 3;
    send_datagram('{8'hFF});                        // one byte
    send_datagram('{8'h00, 8'h00, 8'h05});          // short wins over bad fragment
    send_datagram('{8'h00, 8'h00, 8'h00, AtypName}); // ends on ATYP of a name
    send_datagram('{8'h00, 8'h00, 8'h01, AtypIpv4, 8'hAA}); // fragment error drops ATYP
    send_datagram('{8'hFF, 8'hFF, 8'h00, 8'h02, 8'h11, 8'h22}); // unknown address type
    send_datagram('{8'h00, 8'h00, 8'h00, 8'h00});   // unknown type on the last byte
    send_datagram('{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00});
    send_datagram('{8'h00, 8'h00, 8'h00, AtypName, 8'h05}); // length on the last byte
    d = make_header(AtypIpv4, 0);
    d.pop_back();
    send_datagram(d);                                // IPv4 one byte short
    d = make_header(AtypIpv4, 0);
    add_byte(d, 8'h00);
    add_byte(d, 8'hFF);
    send_datagram(d);
    d = make_header(AtypIpv6, 0);
    d.pop_back();
    send_datagram(d);                                // IPv6 one byte short
    send_datagram(make_header(AtypIpv6, 0));
    send_datagram(make_header(AtypName, 0));         // empty hostname
    d = make_header(AtypName, 3);
    d.pop_back();
    send_datagram(d);                                // hostname header one byte short
  endtask

  // Receiver stops for a long stretch while the sender keeps offering bytes
  task automatic test_receiver_holdoff();
    dgram_t d;
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_hold_cycles = 300;
    d = make_header(AtypIpv4, 0);
    repeat (30) add_byte(d, rand_byte());
    send_datagram(d);
  endtask

  // Position saturates; a 255-byte hostname reaches the top field indexes
  task automatic test_oversize_datagram();
    dgram_t d;
    tx_gap_max = 0;
    rx_gap_max = 0;
    d = make_header(AtypName, 255);
    while (d.size() < MaxBytes + 3) add_byte(d, rand_byte());
    send_datagram(d);
  endtask

  // Mostly well-formed headers with random content, some broken, some noise
  task automatic test_random_datagrams();
    dgram_t      d;
    int unsigned sent, pick, cut, len;
    logic [7:0]  atyp;
    sent = 0;
    while (sent < RandomBytes) begin
      case ($urandom_range(3, 0))
        0:       tx_gap_max = 0;
        1:       tx_gap_max = 3;
        default: tx_gap_max = 17;
      endcase
      case ($urandom_range(3, 0))
        0:       rx_gap_max = 0;
        1:       rx_gap_max = 3;
        default: rx_gap_max = 17;
      endcase
      pick = $urandom_range(99, 0);
      if (pick < 70) begin
        case ($urandom_range(2, 0))
          0:       atyp = AtypIpv4;
          1:       atyp = AtypName;
          default: atyp = AtypIpv6;
        endcase
        len = ($urandom_range(24, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(12, 0);
        d = make_header(atyp, len);
        repeat ($urandom_range(12, 0)) add_byte(d, rand_byte());
        if ($urandom_range(4, 0) == 0) begin
          cut = $urandom_range(d.size(), 1);
          d = d[0:cut-1];
        end
      end else if (pick < 85) begin
        d = make_header(AtypIpv4, 0);
        if ($urandom_range(1, 0) == 0) d[PosFrag] = 8'($urandom_range(255, 1));
        else d[PosAtyp] = rand_byte();
        repeat ($urandom_range(6, 0)) add_byte(d, rand_byte());
      end else begin
        d = {};
        repeat ($urandom_range(30, 1)) add_byte(d, rand_byte());
      end
      send_datagram(d);
      sent += d.size();
    end
  endtask

  initial begin
    fail_cnt       = 0;
    tx_gap_max     = 0;
    rx_gap_max     = 0;
    rx_hold_cycles = 0;
    clear_parser();
    rst_ni   = 1'b0;
    in_valid <= 1'b0;
    in_byte  <= 8'h00;
    in_last  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_headers();
    test_receiver_holdoff();
    test_oversize_datagram();
    test_random_datagrams();
    in_valid <= 1'b0;

    // drain, then wait for any stray transfer
    @(posedge clk_i);
    while (role_exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** socks5_udp_header_deframer: PASSED **");
    end else begin
      $display("** socks5_udp_header_deframer: FAILED **");
    end
    $finish;
  end

endmodule
